>>> rtl/core/q24_alu_pkg.sv
// ----------------------------------------------------------------------------
// Q24.8 ALU package
// Operation codes, word types and shared constants for the fixed-point ALU.
// ----------------------------------------------------------------------------
package q24_alu_pkg;

    localparam int DATA_W       = 32;
    localparam int FRAC_BITS_DF = 8;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_TO_INT   = 4'd14,
        OP_FROM_INT = 4'd15
    } op_t;

    typedef struct packed {
        logic [3:0]               operation;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } alu_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_raw;
        logic                     condition;
        logic                     divide_by_zero;
    } alu_out_t;

    // Side information that rides along the divider chain with each word.
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              neg;
        logic              dz;
        logic              cond;
        logic [DATA_W-1:0] res;
    } cell_ctl_t;

endpackage

>>> rtl/core/q24_alu_cell.sv
// ----------------------------------------------------------------------------
// Q24.8 ALU divider cell
// One restoring-division step: shifts one dividend bit into the partial
// remainder, subtracts the divisor when it fits and shifts in a quotient bit.
// ----------------------------------------------------------------------------
module q24_alu_cell
    import q24_alu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DF
)(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cell_ctl_t                       ctl_in,
    input  logic [DATA_W-1:0]               dvs_in,
    input  logic [DATA_W:0]                 rem_in,
    input  logic [DATA_W+FRAC_BITS-1:0]     dq_in,
    output cell_ctl_t                       ctl_out,
    output logic [DATA_W-1:0]               dvs_out,
    output logic [DATA_W:0]                 rem_out,
    output logic [DATA_W+FRAC_BITS-1:0]     dq_out
);

    localparam int DQ_W = DATA_W + FRAC_BITS;

    cell_ctl_t             ctl_reg;
    logic [DATA_W-1:0]     dvs_reg;
    logic [DATA_W:0]       rem_reg, rem_next, rem_sh;
    logic [DQ_W-1:0]       dq_reg, dq_next;
    logic                  fits;

    always_comb
    begin
        rem_sh   = {rem_in[DATA_W-1:0], dq_in[DQ_W-1]};
        fits     = rem_sh >= {1'b0, dvs_in};
        rem_next = fits ? (rem_sh - {1'b0, dvs_in}) : rem_sh;
        dq_next  = {dq_in[DQ_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        dvs_reg <= dvs_in;
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
    end

    assign ctl_out = ctl_reg;
    assign dvs_out = dvs_reg;
    assign rem_out = rem_reg;
    assign dq_out  = dq_reg;

endmodule

>>> rtl/core/q24_8_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// Q24.8 fixed-point ALU
// Signed fixed-point arithmetic, compares and conversions on 32-bit words.
// ----------------------------------------------------------------------------
// Usage: drive in_word and raise start for one cycle per operation. The word
// is taken at a rising edge with start high and busy low; busy stays low, so
// a new word may be issued in every cycle. Each input word gives exactly one
// result word on out_word, shown for one cycle with done high, in issue order.
// From the accepting edge to the edge that takes the result, each Q24.8 word
// passes one input register that also holds the 64-bit product, one cell per
// quotient bit (32 + FRAC_BITS cells) and an output register, in that order.
// The simple operations and the divide setup settle between the input register
// and the first cell. Throughput is one word per cycle. The receiver cannot
// stall, so results are never held.
// Reset clears every valid flag in the chain; words in flight are dropped.
// A zero divisor gives a zero result with divide_by_zero set.
// ----------------------------------------------------------------------------
module q24_8_fixed_point_alu
    import q24_alu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DF
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  alu_in_t  in_word,
    output logic     done,
    output alu_out_t out_word
);

    localparam int DQ_W   = DATA_W + FRAC_BITS;
    localparam int NCELLS = DQ_W;

    // Input stage.
    logic                     va_reg;
    logic [3:0]               op_reg;
    logic signed [DATA_W-1:0] a_reg, b_reg;
    logic signed [63:0]       prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= in_word.operation;
        a_reg    <= in_word.operand_a;
        b_reg    <= in_word.operand_b;
        prod_reg <= 64'(in_word.operand_a) * 64'(in_word.operand_b);
    end

    assign busy = 1'b0;

    // Finish the simple operations and set up the divide.
    cell_ctl_t              ctl0;
    logic [DATA_W-1:0]      a_mag, b_mag;
    logic signed [63:0]     prod_sh;
    logic signed [DATA_W:0] a_bias;

    always_comb
    begin
        a_mag   = a_reg[DATA_W-1] ? DATA_W'(-a_reg) : DATA_W'(a_reg);
        b_mag   = b_reg[DATA_W-1] ? DATA_W'(-b_reg) : DATA_W'(b_reg);
        prod_sh = prod_reg >>> FRAC_BITS;
        a_bias  = (DATA_W+1)'(a_reg) + (DATA_W+1)'({1'b0, {FRAC_BITS{1'b1}}});
        ctl0        = '0;
        ctl0.valid  = va_reg;
        ctl0.neg    = a_reg[DATA_W-1] ^ b_reg[DATA_W-1];
        case (op_t'(op_reg))
            OP_ADD:      ctl0.res = DATA_W'(a_reg + b_reg);
            OP_SUB:      ctl0.res = DATA_W'(a_reg - b_reg);
            OP_MUL:      ctl0.res = prod_sh[DATA_W-1:0];
            OP_DIV:
            begin
                ctl0.is_div = 1'b1;
                ctl0.dz     = (b_reg == '0);
            end
            OP_GT:       ctl0.cond = a_reg > b_reg;
            OP_LT:       ctl0.cond = a_reg < b_reg;
            OP_GE:       ctl0.cond = a_reg >= b_reg;
            OP_LE:       ctl0.cond = a_reg <= b_reg;
            OP_EQ:       ctl0.cond = a_reg == b_reg;
            OP_NE:       ctl0.cond = a_reg != b_reg;
            OP_MIN:      ctl0.res = (a_reg < b_reg) ? a_reg : b_reg;
            OP_MAX:      ctl0.res = (a_reg > b_reg) ? a_reg : b_reg;
            OP_INC:      ctl0.res = DATA_W'(a_reg + 1);
            OP_DEC:      ctl0.res = DATA_W'(a_reg - 1);
            // Truncation toward zero: bias negative values before the shift.
            OP_TO_INT:   ctl0.res = a_reg[DATA_W-1] ? DATA_W'(a_bias >>> FRAC_BITS)
                                                    : DATA_W'(a_reg >>> FRAC_BITS);
            OP_FROM_INT: ctl0.res = DATA_W'(a_reg <<< FRAC_BITS);
            default:     ctl0.res = '0;
        endcase
    end

    // Divider chain.
    cell_ctl_t         ctl_c [NCELLS+1];
    logic [DATA_W-1:0] dvs_c [NCELLS+1];
    logic [DATA_W:0]   rem_c [NCELLS+1];
    logic [DQ_W-1:0]   dq_c  [NCELLS+1];

    assign ctl_c[0] = ctl0;
    assign dvs_c[0] = b_mag;
    assign rem_c[0] = '0;
    assign dq_c[0]  = {a_mag, {FRAC_BITS{1'b0}}};

    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        q24_alu_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_c[i]),
            .dvs_in  (dvs_c[i]),
            .rem_in  (rem_c[i]),
            .dq_in   (dq_c[i]),
            .ctl_out (ctl_c[i+1]),
            .dvs_out (dvs_c[i+1]),
            .rem_out (rem_c[i+1]),
            .dq_out  (dq_c[i+1])
        );
    end

    // Output register.
    cell_ctl_t         ctl_l;
    logic [DATA_W-1:0] q_low;
    logic              done_reg;
    alu_out_t          out_reg, out_next;

    always_comb
    begin
        ctl_l = ctl_c[NCELLS];
        q_low = ctl_l.neg ? DATA_W'(-dq_c[NCELLS]) : dq_c[NCELLS][DATA_W-1:0];
        out_next.condition      = ctl_l.cond;
        out_next.divide_by_zero = ctl_l.dz;
        if (ctl_l.is_div)
        begin
            out_next.result_raw = ctl_l.dz ? '0 : q_low;
        end
        else
        begin
            out_next.result_raw = ctl_l.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_l.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done     = done_reg;
    assign out_word = out_reg;

`ifndef ASSERT_OFF
    a_done_follows_chain: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_c[NCELLS].valid |=> done)
        else $error("chain output word was not presented");

    a_dz_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_word.divide_by_zero) |-> (out_word.result_raw == '0))
        else $error("divide by zero with nonzero result");

    a_cond_excl_dz: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(out_word.condition && out_word.divide_by_zero))
        else $error("compare and divide flags both set");

    a_issue_enters_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 ctl_c[1].valid)
        else $error("issued word did not enter the divider chain");
`endif

endmodule

>>> test/tb_q24_8_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// Q24.8 fixed-point ALU testbench
// Drives directed and random operation words, predicts each result word from
// the operands and compares it with the block's output in issue order.
// ----------------------------------------------------------------------------
module tb_q24_8_fixed_point_alu;
    import q24_alu_pkg::*;

    localparam int LATENCY = FRAC_BITS_DF + 34;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    alu_in_t  in_word;
    logic     done;
    alu_out_t out_word;

    alu_in_t  pending_words[$];
    alu_out_t expected_results[$];
    int       error_count;
    bit       quiet_mode;
    bit       hold_for_drain;

    q24_8_fixed_point_alu u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .in_word  (in_word),
        .done     (done),
        .out_word (out_word)
    );

    function automatic alu_out_t compute_alu(alu_in_t w);
        alu_out_t         r;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [63:0] wide;
        r = '0;
        a = w.operand_a;
        b = w.operand_b;
        case (op_t'(w.operation))
            OP_ADD:      r.result_raw = a + b;
            OP_SUB:      r.result_raw = a - b;
            OP_MUL:
            begin
                wide = 64'(a) * 64'(b);
                r.result_raw = wide[39:8];
            end
            OP_DIV:
            begin
                if (b == 0)
                    r.divide_by_zero = 1'b1;
                else
                begin
                    wide = (64'(a) <<< 8) / 64'(b);
                    r.result_raw = wide[31:0];
                end
            end
            OP_GT:       r.condition = a > b;
            OP_LT:       r.condition = a < b;
            OP_GE:       r.condition = a >= b;
            OP_LE:       r.condition = a <= b;
            OP_EQ:       r.condition = a == b;
            OP_NE:       r.condition = a != b;
            OP_MIN:      r.result_raw = (a < b) ? a : b;
            OP_MAX:      r.result_raw = (a > b) ? a : b;
            OP_INC:      r.result_raw = a + 32'sd1;
            OP_DEC:      r.result_raw = a - 32'sd1;
            OP_TO_INT:   r.result_raw = a / 32'sd256;
            default:     r.result_raw = a << 8;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000 + $urandom_range(0, 3);
            1:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2:       return 32'($urandom_range(0, 4)) - 32'd2;
            3:       return 32'($signed($urandom_range(0, 65535)) - 32768);
            default: return $urandom;
        endcase
    endfunction

    function automatic alu_in_t make_word(op_t op, logic [31:0] a, logic [31:0] b);
        alu_in_t w;
        w.operation = op;
        w.operand_a = a;
        w.operand_b = b;
        return w;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        logic [31:0] edge_vals[6];
        alu_in_t     w;
        edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                      32'hFFFF_FFFF, 32'h100, 32'hFFFF_FF00};
        rst_n = 1'b0;
        hold_for_drain = 1'b0;
        // Directed part: every operation on the extreme operands, plus a zero divisor and other corner words.
        for (int op = 0; op < 16; op++)
            pending_words.push_back(make_word(op_t'(op), edge_vals[op % 6],
                                              edge_vals[(op + 1) % 6]));
        pending_words.push_back(make_word(OP_DIV, 32'h7FFF_FFFF, 32'h0));
        pending_words.push_back(make_word(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF));
        pending_words.push_back(make_word(OP_MUL, 32'h8000_0000, 32'h8000_0000));
        pending_words.push_back(make_word(OP_TO_INT, 32'hFFFF_FF01, 32'h1234_5678));
        pending_words.push_back(make_word(OP_EQ, 32'h5, 32'h5));
        pending_words.push_back(make_word(OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        pending_words.push_back(make_word(OP_DEC, 32'h8000_0000, 32'h0));
        for (int i = 0; i < 400; i++)
        begin
            w.operation = 4'($urandom_range(0, 15));
            w.operand_a = random_operand();
            w.operand_b = ($urandom_range(0, 15) == 0) ? w.operand_a : random_operand();
            if (w.operation == OP_DIV && $urandom_range(0, 7) == 0)
                w.operand_b = '0;
            pending_words.push_back(w);
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_words.size() < 200);
        // Let the pipeline drain completely before continuing.
        hold_for_drain = 1'b1;
        wait (expected_results.size() == 0 && !start);
        @(posedge clk);
        hold_for_drain = 1'b0;
        wait (pending_words.size() == 0 && !start);
        wait (expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Driver: one word per accepted start, with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            in_word    <= '0;
            quiet_mode = 1'b0;
        end
        else
        begin
            if (start && !busy)
                expected_results.push_back(compute_alu(in_word));
            if ($urandom_range(0, 199) == 0)
                quiet_mode = !quiet_mode;
            if (!(start && busy))
            begin
                if (pending_words.size() > 0 && !hold_for_drain
                    && (quiet_mode || $urandom_range(0, 99) >= 23))
                begin
                    in_word <= pending_words.pop_front();
                    start   <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed word is checked against the oldest prediction.
    always @(posedge clk)
    begin
        alu_out_t exp_word;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, out_word);
                error_count++;
            end
            else
            begin
                exp_word = expected_results.pop_front();
                if (out_word.result_raw !== exp_word.result_raw)
                begin
                    $display("%0t: result_raw expected %h actual %h", $time,
                             exp_word.result_raw, out_word.result_raw);
                    error_count++;
                end
                if (out_word.condition !== exp_word.condition)
                begin
                    $display("%0t: condition expected %b actual %b", $time,
                             exp_word.condition, out_word.condition);
                    error_count++;
                end
                if (out_word.divide_by_zero !== exp_word.divide_by_zero)
                begin
                    $display("%0t: divide_by_zero expected %b actual %b", $time,
                             exp_word.divide_by_zero, out_word.divide_by_zero);
                    error_count++;
                end
            end
        end
    end

endmodule
